// ===== hdl/pcpa_pkg.sv =====
// ----------------------------------------------------------------------------
// pcpa_pkg
// Shared constants, codes, control word layout and microcode table for the
// per-cpu page allocator.
// ----------------------------------------------------------------------------
package pcpa_pkg;

   // default sizes
   localparam int DEFAULT_NUM_CPUS  = 8;
   localparam int DEFAULT_NUM_PAGES = 1024;

   // field widths
   localparam int OP_W        = 1;
   localparam int CPU_FIELD_W = 3;
   localparam int PAGE_W      = 10;
   localparam int COUNT_W     = 11;
   localparam int STATUS_W    = 2;
   localparam int MOVED_W     = 10;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 11;

   localparam int MAX_LINK_DEPTH = 1 << PAGE_W;

   // request operations
   localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
   localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

   // response status
   localparam logic [STATUS_W-1:0] RSP_ALLOCATED = 2'd0;
   localparam logic [STATUS_W-1:0] RSP_NO_MEMORY = 2'd1;
   localparam logic [STATUS_W-1:0] RSP_FREED     = 2'd2;
   localparam logic [STATUS_W-1:0] RSP_REJECTED  = 2'd3;

   // configuration registers
   localparam logic [CSR_INDEX_W-1:0] CSR_LOWEST_PAGE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAGE_LIMIT  = 1'b1;
   localparam logic [PAGE_W-1:0]      LOWEST_RESET    = 10'd0;
   localparam logic [COUNT_W-1:0]     LIMIT_RESET     = 11'd1024;

   // one entry of the per-cpu list table
   typedef struct packed {
      logic [PAGE_W-1:0]  head;
      logic [COUNT_W-1:0] count;
   } lt_entry_type;

   // microcode address
   localparam int UPC_W = 4;
   typedef logic [UPC_W-1:0] upc_type;

   localparam upc_type UPC_IDLE       = 4'd0;
   localparam upc_type UPC_FREE_1     = 4'd1;
   localparam upc_type UPC_ALLOC_1    = 4'd2;
   localparam upc_type UPC_ALLOC_2    = 4'd3;
   localparam upc_type UPC_STEAL_INIT = 4'd4;
   localparam upc_type UPC_STEAL_READ = 4'd5;
   localparam upc_type UPC_STEAL_TEST = 4'd6;
   localparam upc_type UPC_STEAL_NEXT = 4'd7;
   localparam upc_type UPC_OOM        = 4'd8;
   localparam upc_type UPC_FOUND      = 4'd9;
   localparam upc_type UPC_WALK       = 4'd10;
   localparam upc_type UPC_VICTIM     = 4'd11;
   localparam upc_type UPC_GIVE       = 4'd12;

   // list table read address select
   typedef logic [1:0] lt_rd_type;
   localparam lt_rd_type LT_RD_NONE = 2'd0;
   localparam lt_rd_type LT_RD_REQ  = 2'd1;
   localparam lt_rd_type LT_RD_SCAN = 2'd2;

   // link memory read address select
   typedef logic [1:0] link_rd_type;
   localparam link_rd_type LINK_RD_NONE  = 2'd0;
   localparam link_rd_type LINK_RD_HEAD  = 2'd1;
   localparam link_rd_type LINK_RD_CHAIN = 2'd2;

   // list table write select
   typedef logic [2:0] lt_wr_type;
   localparam lt_wr_type LT_WR_NONE      = 3'd0;
   localparam lt_wr_type LT_WR_PUSH      = 3'd1;
   localparam lt_wr_type LT_WR_POP       = 3'd2;
   localparam lt_wr_type LT_WR_VICTIM    = 3'd3;
   localparam lt_wr_type LT_WR_REQUESTER = 3'd4;

   // scan pointer operation
   typedef logic [1:0] scan_op_type;
   localparam scan_op_type SCAN_NONE = 2'd0;
   localparam scan_op_type SCAN_INIT = 2'd1;
   localparam scan_op_type SCAN_STEP = 2'd2;

   // response kind
   typedef logic [2:0] emit_type;
   localparam emit_type EMIT_NONE  = 3'd0;
   localparam emit_type EMIT_FREE  = 3'd1;
   localparam emit_type EMIT_LOCAL = 3'd2;
   localparam emit_type EMIT_OOM   = 3'd3;
   localparam emit_type EMIT_STEAL = 3'd4;

   // jump conditions
   typedef logic [2:0] cond_type;
   localparam cond_type COND_NEVER     = 3'd0;
   localparam cond_type COND_ALWAYS    = 3'd1;
   localparam cond_type COND_REQ_ALLOC = 3'd2;
   localparam cond_type COND_LT_EMPTY  = 3'd3;
   localparam cond_type COND_SCAN_LAST = 3'd4;
   localparam cond_type COND_WALK_MORE = 3'd5;

   typedef struct packed {
      logic        accept;
      lt_rd_type   lt_rd;
      link_rd_type link_rd;
      lt_wr_type   lt_wr;
      logic        link_wr;
      logic        latch_lt;
      scan_op_type scan;
      logic        walk_init;
      logic        walk_step;
      emit_type    emit;
      cond_type    cond;
      logic        cond_inv;
      upc_type     target;
   } ctrl_word_type;

   // microcode table: next step is target when the condition holds, else upc + 1
   function automatic ctrl_word_type ucode_rom(input upc_type upc);
      ctrl_word_type w;
      w = '0;
      unique case (upc)
         UPC_IDLE: begin
            w.accept = 1'b1;
            w.lt_rd  = LT_RD_REQ;
            w.cond   = COND_REQ_ALLOC;
            w.target = UPC_ALLOC_1;
         end
         UPC_FREE_1: begin
            w.link_wr = 1'b1;
            w.lt_wr   = LT_WR_PUSH;
            w.emit    = EMIT_FREE;
            w.cond    = COND_ALWAYS;
            w.target  = UPC_IDLE;
         end
         UPC_ALLOC_1: begin
            w.latch_lt = 1'b1;
            w.link_rd  = LINK_RD_HEAD;
            w.cond     = COND_LT_EMPTY;
            w.target   = UPC_STEAL_INIT;
         end
         UPC_ALLOC_2: begin
            w.lt_wr  = LT_WR_POP;
            w.emit   = EMIT_LOCAL;
            w.cond   = COND_ALWAYS;
            w.target = UPC_IDLE;
         end
         UPC_STEAL_INIT: begin
            w.scan = SCAN_INIT;
         end
         UPC_STEAL_READ: begin
            w.lt_rd = LT_RD_SCAN;
         end
         UPC_STEAL_TEST: begin
            w.cond     = COND_LT_EMPTY;
            w.cond_inv = 1'b1;
            w.target   = UPC_FOUND;
         end
         UPC_STEAL_NEXT: begin
            w.scan     = SCAN_STEP;
            w.cond     = COND_SCAN_LAST;
            w.cond_inv = 1'b1;
            w.target   = UPC_STEAL_READ;
         end
         UPC_OOM: begin
            w.emit   = EMIT_OOM;
            w.cond   = COND_ALWAYS;
            w.target = UPC_IDLE;
         end
         UPC_FOUND: begin
            w.latch_lt  = 1'b1;
            w.link_rd   = LINK_RD_HEAD;
            w.walk_init = 1'b1;
         end
         UPC_WALK: begin
            w.link_rd   = LINK_RD_CHAIN;
            w.walk_step = 1'b1;
            w.cond      = COND_WALK_MORE;
            w.target    = UPC_WALK;
         end
         UPC_VICTIM: begin
            w.lt_wr = LT_WR_VICTIM;
         end
         UPC_GIVE: begin
            w.lt_wr  = LT_WR_REQUESTER;
            w.emit   = EMIT_STEAL;
            w.cond   = COND_ALWAYS;
            w.target = UPC_IDLE;
         end
         default: begin
            w.cond   = COND_ALWAYS;
            w.target = UPC_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== hdl/per_cpu_page_allocator.sv =====
// ----------------------------------------------------------------------------
// per_cpu_page_allocator
// Each cpu owns a LIFO free list of page frames, linked through a next-link
// memory, with a head and a count per list kept in a small list table. A free
// pushes onto the caller's list (frames outside [lowest_page, page_limit) or
// beyond NUM_PAGES are rejected); an allocate pops from the caller's list and,
// when that list is empty, scans the other cpus from cpu+1 and splits off the
// first max(1, count/2) pages of the first non-empty list. A small microcode
// sequencer drives the datapath, and both memories have one registered read
// port; a steal reads the list table entry of each scanned cpu in turn, then
// walks the victim's chain one link per cycle. A new request is taken while
// the previous response still waits in the output register. No clearing pass
// after reset.
// ----------------------------------------------------------------------------
module per_cpu_page_allocator #(
   parameter int NUM_CPUS  = pcpa_pkg::DEFAULT_NUM_CPUS,
   parameter int NUM_PAGES = pcpa_pkg::DEFAULT_NUM_PAGES
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [pcpa_pkg::OP_W-1:0]           req_operation,
   input  logic [pcpa_pkg::CPU_FIELD_W-1:0]    req_cpu,
   input  logic [pcpa_pkg::PAGE_W-1:0]         req_page,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [pcpa_pkg::STATUS_W-1:0]       rsp_status,
   output logic [pcpa_pkg::PAGE_W-1:0]         rsp_granted_page,
   output logic [pcpa_pkg::MOVED_W-1:0]        rsp_pages_moved,
   // configuration write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pcpa_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pcpa_pkg::CSR_DATA_W-1:0]     csr_data
);
   import pcpa_pkg::*;

   localparam int CPU_W      = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
   localparam int LINK_DEPTH = (NUM_PAGES < MAX_LINK_DEPTH) ? NUM_PAGES : MAX_LINK_DEPTH;
   localparam int LINK_AW    = (LINK_DEPTH > 1) ? $clog2(LINK_DEPTH) : 1;
   localparam logic [6:0]       NUM_CPUS_W7 = 7'(NUM_CPUS);
   localparam logic [CPU_W-1:0] LAST_CPU    = CPU_W'(NUM_CPUS - 1);
   localparam logic [20:0]      PAGES_BOUND = 21'(NUM_PAGES);

   // sequencer
   upc_type       upc_ff, upc_in;
   ctrl_word_type ctrl;
   logic          accepted, hold, advance, cond_val, taken;

   // configuration
   logic [PAGE_W-1:0]  lowest_ff, lowest_in;
   logic [COUNT_W-1:0] limit_ff, limit_in;

   // request registers
   logic [CPU_W-1:0]  cpu_ff, cpu_in, cpu_mod;
   logic [PAGE_W-1:0] page_ff, page_in;
   logic [6:0]        cpu_wide;

   // list table memory
   lt_entry_type             lt_mem [NUM_CPUS];
   lt_entry_type             lt_rd_ff, lt_wdata;
   logic                     lt_rv_ff;
   logic [NUM_CPUS-1:0]      lt_valid_ff, lt_valid_in;
   logic                     lt_re, lt_we;
   logic [CPU_W-1:0]         lt_raddr, lt_waddr;
   logic [PAGE_W-1:0]        lt_head;
   logic [COUNT_W-1:0]       lt_count;

   // link memory
   logic [PAGE_W-1:0]  link_mem [LINK_DEPTH];
   logic [PAGE_W-1:0]  link_rd_ff;
   logic               link_re, link_we;
   logic [LINK_AW-1:0] link_raddr;

   // datapath registers
   logic [PAGE_W-1:0]  head_ff, head_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [CPU_W-1:0]   scan_ff, scan_in, scan_from_cpu, scan_from_scan;
   logic [MOVED_W-1:0] k_ff, k_in;
   logic [PAGE_W-1:0]  second_ff, second_in;
   logic               walk_more, in_range, emit_fire;

   // response registers
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [PAGE_W-1:0]   rsp_page_ff, rsp_page_in;
   logic [MOVED_W-1:0]  rsp_moved_ff, rsp_moved_in;

   // ------------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------------
   assign ctrl      = ucode_rom(upc_ff);
   assign req_ready = ctrl.accept;
   assign accepted  = req_valid & req_ready;

   // wait for a transaction, or for room in the response register
   assign hold = (ctrl.accept & ~req_valid) |
                 ((ctrl.emit != EMIT_NONE) & rsp_valid_ff & ~rsp_ready);
   assign advance = ~hold;

   always_comb begin
      unique case (ctrl.cond)
         COND_NEVER:     cond_val = 1'b0;
         COND_ALWAYS:    cond_val = 1'b1;
         COND_REQ_ALLOC: cond_val = (req_operation == OP_ALLOC);
         COND_LT_EMPTY:  cond_val = (lt_count == '0);
         COND_SCAN_LAST: cond_val = (scan_from_scan == cpu_ff);
         COND_WALK_MORE: cond_val = walk_more;
         default:        cond_val = 1'b0;
      endcase
   end

   assign taken = cond_val ^ ctrl.cond_inv;

   always_comb begin
      if (hold) begin
         upc_in = upc_ff;
      end else if (taken) begin
         upc_in = ctrl.target;
      end else begin
         upc_in = upc_ff + 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // configuration
   // ------------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_comb begin
      lowest_in = lowest_ff;
      limit_in  = limit_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_LOWEST_PAGE: lowest_in = csr_data[PAGE_W-1:0];
            CSR_PAGE_LIMIT:  limit_in  = csr_data;
            default:         limit_in  = limit_ff;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // request capture, cpu index folded into range
   // ------------------------------------------------------------------------
   always_comb begin
      cpu_wide = {4'd0, req_cpu};
      for (int i = 0; i < 3; i++) begin
         if (cpu_wide >= NUM_CPUS_W7) begin
            cpu_wide = cpu_wide - NUM_CPUS_W7;
         end
      end
      cpu_mod = cpu_wide[CPU_W-1:0];
   end

   assign cpu_in  = accepted ? cpu_mod  : cpu_ff;
   assign page_in = accepted ? req_page : page_ff;

   assign in_range = (page_ff >= lowest_ff) && ({1'b0, page_ff} < limit_ff) &&
                     ({11'd0, page_ff} < PAGES_BOUND);

   // ------------------------------------------------------------------------
   // list table
   // ------------------------------------------------------------------------
   assign lt_re    = advance & (ctrl.lt_rd != LT_RD_NONE) & (~ctrl.accept | accepted);
   assign lt_raddr = (ctrl.lt_rd == LT_RD_SCAN) ? scan_ff : cpu_mod;

   // an entry never written reads as an empty list
   assign lt_head  = lt_rv_ff ? lt_rd_ff.head  : '0;
   assign lt_count = lt_rv_ff ? lt_rd_ff.count : '0;

   always_comb begin
      lt_we    = 1'b0;
      lt_waddr = cpu_ff;
      lt_wdata = '0;
      unique case (ctrl.lt_wr)
         LT_WR_NONE: begin
            lt_we = 1'b0;
         end
         LT_WR_PUSH: begin
            lt_we    = in_range;
            lt_wdata = '{head: page_ff, count: lt_count + 1'b1};
         end
         LT_WR_POP: begin
            lt_we    = 1'b1;
            lt_wdata = '{head: link_rd_ff, count: cnt_ff - 1'b1};
         end
         LT_WR_VICTIM: begin
            lt_we    = 1'b1;
            lt_waddr = scan_ff;
            lt_wdata = '{head: link_rd_ff, count: cnt_ff - {1'b0, k_ff}};
         end
         LT_WR_REQUESTER: begin
            // a single stolen page leaves the requester's list alone
            lt_we    = (k_ff > MOVED_W'(1));
            lt_wdata = '{head: second_ff, count: {1'b0, k_ff} - 1'b1};
         end
         default: begin
            lt_we = 1'b0;
         end
      endcase
      lt_we = lt_we & advance;
   end

   always_comb begin
      lt_valid_in = lt_valid_ff;
      if (lt_we) begin
         lt_valid_in[lt_waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (lt_we) begin
         lt_mem[lt_waddr] <= lt_wdata;
      end
      if (lt_re) begin
         lt_rd_ff <= lt_mem[lt_raddr];
         lt_rv_ff <= lt_valid_ff[lt_raddr];
      end
   end

   // ------------------------------------------------------------------------
   // link memory
   // ------------------------------------------------------------------------
   assign walk_more = (k_ff < cnt_ff[COUNT_W-1:1]);
   assign link_we   = advance & ctrl.link_wr & in_range;

   always_comb begin
      link_re    = 1'b0;
      link_raddr = lt_head[LINK_AW-1:0];
      unique case (ctrl.link_rd)
         LINK_RD_NONE: begin
            link_re = 1'b0;
         end
         LINK_RD_HEAD: begin
            link_re = advance;
         end
         LINK_RD_CHAIN: begin
            // follow the chain one link per cycle
            link_re    = advance & walk_more;
            link_raddr = link_rd_ff[LINK_AW-1:0];
         end
         default: begin
            link_re = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[page_ff[LINK_AW-1:0]] <= lt_head;
      end
      if (link_re) begin
         link_rd_ff <= link_mem[link_raddr];
      end
   end

   // ------------------------------------------------------------------------
   // scan and walk registers
   // ------------------------------------------------------------------------
   assign scan_from_cpu  = (cpu_ff  == LAST_CPU) ? '0 : cpu_ff  + 1'b1;
   assign scan_from_scan = (scan_ff == LAST_CPU) ? '0 : scan_ff + 1'b1;

   always_comb begin
      scan_in = scan_ff;
      if (advance) begin
         case (ctrl.scan)
            SCAN_INIT: scan_in = scan_from_cpu;
            SCAN_STEP: scan_in = scan_from_scan;
            default:   scan_in = scan_ff;
         endcase
      end
   end

   always_comb begin
      head_in   = head_ff;
      cnt_in    = cnt_ff;
      k_in      = k_ff;
      second_in = second_ff;
      if (advance && ctrl.latch_lt) begin
         head_in = lt_head;
         cnt_in  = lt_count;
      end
      if (advance && ctrl.walk_init) begin
         k_in = MOVED_W'(1);
      end
      if (advance && ctrl.walk_step && walk_more) begin
         k_in = k_ff + 1'b1;
         if (k_ff == MOVED_W'(1)) begin
            second_in = link_rd_ff;
         end
      end
   end

   // ------------------------------------------------------------------------
   // response register
   // ------------------------------------------------------------------------
   assign emit_fire = advance & (ctrl.emit != EMIT_NONE);

   always_comb begin
      rsp_status_in = rsp_status_ff;
      rsp_page_in   = rsp_page_ff;
      rsp_moved_in  = rsp_moved_ff;
      if (emit_fire) begin
         rsp_page_in  = '0;
         rsp_moved_in = '0;
         case (ctrl.emit)
            EMIT_FREE: begin
               rsp_status_in = in_range ? RSP_FREED : RSP_REJECTED;
            end
            EMIT_LOCAL: begin
               rsp_status_in = RSP_ALLOCATED;
               rsp_page_in   = head_ff;
            end
            EMIT_STEAL: begin
               rsp_status_in = RSP_ALLOCATED;
               rsp_page_in   = head_ff;
               rsp_moved_in  = k_ff;
            end
            default: begin
               rsp_status_in = RSP_NO_MEMORY;
            end
         endcase
      end
   end

   always_comb begin
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_granted_page = rsp_page_ff;
   assign rsp_pages_moved  = rsp_moved_ff;

   // ------------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= UPC_IDLE;
         lowest_ff    <= LOWEST_RESET;
         limit_ff     <= LIMIT_RESET;
         lt_valid_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         lowest_ff    <= lowest_in;
         limit_ff     <= limit_in;
         lt_valid_ff  <= lt_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cpu_ff        <= cpu_in;
      page_ff       <= page_in;
      head_ff       <= head_in;
      cnt_ff        <= cnt_in;
      scan_ff       <= scan_in;
      k_ff          <= k_in;
      second_ff     <= second_in;
      rsp_status_ff <= rsp_status_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_moved_ff  <= rsp_moved_in;
   end

endmodule

// ===== tb/per_cpu_page_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_cpu_page_allocator_tb
// Self-checking bench for the per-cpu page allocator. A short directed table
// covers frees, local pops, steals, range rejects and a double free. Random
// phases follow under several range settings. Typed table rows are checked
// against their table entry, every other response against an in-bench model
// of the free lists, with random stalls on the request and response channels.
// ----------------------------------------------------------------------------
module per_cpu_page_allocator_tb;
   import pcpa_pkg::*;

   localparam int NCPU        = DEFAULT_NUM_CPUS;
   localparam int NFRAMES     = DEFAULT_NUM_PAGES;
   localparam int PHASE_ITEMS = 318;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PAGE_W-1:0]   granted;
      logic [MOVED_W-1:0]  moved;
   } page_rsp_type;

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [OP_W-1:0]        op;
      logic [CPU_FIELD_W-1:0] cpu;
      logic [PAGE_W-1:0]      page;
      logic [CSR_INDEX_W-1:0] csr_idx;
      logic [CSR_DATA_W-1:0]  csr_val;
      logic                   typed;
      page_rsp_type           want;
   } plan_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [OP_W-1:0]        req_operation = OP_ALLOC;
   logic [CPU_FIELD_W-1:0] req_cpu = '0;
   logic [PAGE_W-1:0]      req_page = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [STATUS_W-1:0]    rsp_status;
   logic [PAGE_W-1:0]      rsp_granted_page;
   logic [MOVED_W-1:0]     rsp_pages_moved;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_LOWEST_PAGE;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // model of the free lists, advanced as each request transaction is taken
   logic [PAGE_W-1:0]  chain_next [NFRAMES];
   logic [PAGE_W-1:0]  cpu_top [NCPU];
   logic [COUNT_W-1:0] cpu_depth [NCPU];
   logic [PAGE_W-1:0]  cfg_lowest = LOWEST_RESET;
   logic [COUNT_W-1:0] cfg_limit = LIMIT_RESET;
   // how many times each frame currently sits on some list
   int unsigned        on_list [NFRAMES];

   page_rsp_type owed_rsp [$];
   plan_row_type plan [$];

   bit          no_idle = 1'b0;
   int unsigned ready_hold = 0;
   int          bad_count = 0;
   int          n_local = 0;
   int          n_steal = 0;
   int          n_oom = 0;
   int          n_freed = 0;
   int          n_rejected = 0;

   per_cpu_page_allocator u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_cpu          (req_cpu),
      .req_page         (req_page),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_granted_page (rsp_granted_page),
      .rsp_pages_moved  (rsp_pages_moved),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #2 clock = ~clock;

   function automatic bit accepts_frame(input logic [PAGE_W-1:0] p);
      return p >= cfg_lowest && {1'b0, p} < cfg_limit;
   endfunction

   function automatic page_rsp_type serve_request(input logic [OP_W-1:0] op,
                                                  input logic [CPU_FIELD_W-1:0] cpu,
                                                  input logic [PAGE_W-1:0] page);
      page_rsp_type       r;
      int                 i;
      int                 j;
      int                 m;
      logic [COUNT_W-1:0] n;
      logic [COUNT_W-1:0] k;
      logic [PAGE_W-1:0]  tail;
      r = '0;
      if (op == OP_FREE) begin
         if (!accepts_frame(page)) begin
            r.status = RSP_REJECTED;
         end else begin
            chain_next[page] = cpu_top[cpu];
            cpu_top[cpu] = page;
            cpu_depth[cpu] = cpu_depth[cpu] + 1'b1;
            on_list[page]++;
            r.status = RSP_FREED;
         end
      end else if (cpu_depth[cpu] != 0) begin
         r.status = RSP_ALLOCATED;
         r.granted = cpu_top[cpu];
         cpu_top[cpu] = chain_next[r.granted];
         cpu_depth[cpu] = cpu_depth[cpu] - 1'b1;
      end else begin
         r.status = RSP_NO_MEMORY;
         // first non-empty list after the requester gives up max(1, n/2) of its pages
         for (i = 1; i < NCPU; i++) begin
            j = (int'(cpu) + i) % NCPU;
            if (r.status == RSP_NO_MEMORY && cpu_depth[j] != 0) begin
               n = cpu_depth[j];
               k = ((n >> 1) == 0) ? 11'd1 : (n >> 1);
               r.granted = cpu_top[j];
               tail = r.granted;
               for (m = 1; m < int'(k); m++) tail = chain_next[tail];
               cpu_top[j] = chain_next[tail];
               cpu_depth[j] = n - k;
               if (k > 1) begin
                  cpu_top[cpu] = chain_next[r.granted];
                  cpu_depth[cpu] = cpu_depth[cpu] + k - 1'b1;
               end
               r.moved = k[MOVED_W-1:0];
               r.status = RSP_ALLOCATED;
            end
         end
      end
      if (r.status == RSP_ALLOCATED) on_list[r.granted]--;
      return r;
   endfunction

   function automatic int unsigned idle_draw();
      return no_idle ? 0 : $urandom_range(0, 6);
   endfunction

   function automatic plan_row_type req_row(input logic [OP_W-1:0] op, input int cpu,
                                            input int page, input bit typed,
                                            input logic [STATUS_W-1:0] status,
                                            input int granted);
      plan_row_type row;
      row = '0;
      row.kind = ROW_REQ;
      row.op = op;
      row.cpu = CPU_FIELD_W'(cpu);
      row.page = PAGE_W'(page);
      row.typed = typed;
      row.want.status = status;
      row.want.granted = PAGE_W'(granted);
      return row;
   endfunction

   function automatic plan_row_type csr_row(input logic [CSR_INDEX_W-1:0] idx,
                                            input logic [CSR_DATA_W-1:0] val);
      plan_row_type row;
      row = '0;
      row.kind = ROW_CSR;
      row.csr_idx = idx;
      row.csr_val = val;
      return row;
   endfunction

   // valid is left high after the transaction so the next one can follow at once
   task automatic issue_request(input logic [OP_W-1:0] op,
                                input logic [CPU_FIELD_W-1:0] cpu,
                                input logic [PAGE_W-1:0] page,
                                input bit typed, input page_rsp_type typed_rsp);
      int unsigned  gap;
      page_rsp_type predicted;
      gap = idle_draw();
      csr_valid <= 1'b0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_cpu <= cpu;
      req_page <= page;
      do @(posedge clock); while (!req_ready);
      predicted = serve_request(op, cpu, page);
      owed_rsp.push_back(typed ? typed_rsp : predicted);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (owed_rsp.size() != 0) @(posedge clock);
   endtask

   // called only while idle; the next request lowers csr_valid
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_LOWEST_PAGE) cfg_lowest = val[PAGE_W-1:0];
      else cfg_limit = val;
   endtask

   always @(posedge clock) begin : rsp_side
      int unsigned hold;
      if (reset) begin
         rsp_ready <= 1'b0;
         ready_hold <= 0;
      end else if (rsp_valid && rsp_ready) begin
         hold = idle_draw();
         ready_hold <= hold;
         rsp_ready <= (hold == 0);
      end else if (ready_hold > 1) begin
         ready_hold <= ready_hold - 1;
      end else begin
         ready_hold <= 0;
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : rsp_check
      page_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (owed_rsp.size() == 0) begin
            bad_count++;
            if (bad_count <= 10)
               $display("unexpected response at %0t: status %0d page %0d moved %0d",
                        $realtime, rsp_status, rsp_granted_page, rsp_pages_moved);
         end else begin
            want = owed_rsp.pop_front();
            if (rsp_status !== want.status || rsp_granted_page !== want.granted ||
                rsp_pages_moved !== want.moved) begin
               bad_count++;
               if (bad_count <= 10) begin
                  $display("mismatch at %0t: expected status %0d page %0d moved %0d,",
                           $realtime, want.status, want.granted, want.moved);
                  $display("   got status %0d page %0d moved %0d",
                           rsp_status, rsp_granted_page, rsp_pages_moved);
               end
            end
            case (want.status)
               RSP_ALLOCATED: if (want.moved != 0) n_steal++; else n_local++;
               RSP_NO_MEMORY: n_oom++;
               RSP_FREED:     n_freed++;
               default:       n_rejected++;
            endcase
         end
      end
   end

   initial begin : stimulus
      int                     row_i;
      int                     ph;
      int                     n;
      int                     s;
      int                     free_pct;
      int                     run_left;
      int unsigned            hi;
      bit                     found;
      logic [7:0]             free_mask;
      logic [OP_W-1:0]        op;
      logic [CPU_FIELD_W-1:0] cpu;
      logic [PAGE_W-1:0]      page;
      logic [PAGE_W-1:0]      cand;
      logic [CSR_DATA_W-1:0]  lo;
      logic [CSR_DATA_W-1:0]  lim;

      for (n = 0; n < NFRAMES; n++) begin
         chain_next[n] = '0;
         on_list[n] = 0;
      end
      for (n = 0; n < NCPU; n++) begin
         cpu_top[n] = '0;
         cpu_depth[n] = '0;
      end
      run_left = 0;

      // reset range: everything fits
      plan.push_back(req_row(OP_ALLOC, 0, 0, 1'b1, RSP_NO_MEMORY, 0));
      plan.push_back(req_row(OP_FREE, 3, 0, 1'b1, RSP_FREED, 0));
      plan.push_back(req_row(OP_FREE, 3, 1023, 1'b1, RSP_FREED, 0));
      plan.push_back(req_row(OP_FREE, 3, 5, 1'b1, RSP_FREED, 0));
      plan.push_back(req_row(OP_FREE, 3, 6, 1'b1, RSP_FREED, 0));
      plan.push_back(req_row(OP_ALLOC, 3, 0, 1'b1, RSP_ALLOCATED, 6));
      // single-page steals, requester list stays empty; the last one wraps the scan
      plan.push_back(req_row(OP_ALLOC, 2, 0, 1'b0, RSP_ALLOCATED, 0));
      plan.push_back(req_row(OP_ALLOC, 7, 0, 1'b0, RSP_ALLOCATED, 0));
      plan.push_back(req_row(OP_ALLOC, 4, 0, 1'b0, RSP_ALLOCATED, 0));
      plan.push_back(req_row(OP_ALLOC, 4, 0, 1'b1, RSP_NO_MEMORY, 0));
      for (n = 10; n < 15; n++) plan.push_back(req_row(OP_FREE, 1, n, 1'b1, RSP_FREED, 0));
      // steal of two pages, the second lands on the requester
      plan.push_back(req_row(OP_ALLOC, 0, 0, 1'b0, RSP_ALLOCATED, 0));
      plan.push_back(req_row(OP_ALLOC, 0, 0, 1'b0, RSP_ALLOCATED, 0));
      // same frame freed twice comes back twice
      plan.push_back(req_row(OP_FREE, 6, 20, 1'b1, RSP_FREED, 0));
      plan.push_back(req_row(OP_FREE, 6, 20, 1'b1, RSP_FREED, 0));
      plan.push_back(req_row(OP_ALLOC, 6, 0, 1'b1, RSP_ALLOCATED, 20));
      plan.push_back(req_row(OP_ALLOC, 6, 0, 1'b1, RSP_ALLOCATED, 20));
      // bit 10 lies outside lowest_page
      plan.push_back(csr_row(CSR_LOWEST_PAGE, 11'h410));
      plan.push_back(csr_row(CSR_PAGE_LIMIT, 11'd32));
      plan.push_back(req_row(OP_FREE, 5, 15, 1'b1, RSP_REJECTED, 0));
      plan.push_back(req_row(OP_FREE, 5, 32, 1'b1, RSP_REJECTED, 0));
      plan.push_back(req_row(OP_FREE, 5, 16, 1'b1, RSP_FREED, 0));
      plan.push_back(req_row(OP_FREE, 5, 31, 1'b1, RSP_FREED, 0));
      plan.push_back(csr_row(CSR_PAGE_LIMIT, 11'd0));
      plan.push_back(req_row(OP_FREE, 5, 20, 1'b1, RSP_REJECTED, 0));
      plan.push_back(csr_row(CSR_LOWEST_PAGE, 11'd1023));
      plan.push_back(csr_row(CSR_PAGE_LIMIT, 11'd2047));
      plan.push_back(req_row(OP_FREE, 2, 1022, 1'b1, RSP_REJECTED, 0));
      plan.push_back(req_row(OP_FREE, 2, 1023, 1'b1, RSP_FREED, 0));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (row_i = 0; row_i < plan.size(); row_i++) begin
         if (plan[row_i].kind == ROW_CSR) begin
            wait_drained();
            write_csr(plan[row_i].csr_idx, plan[row_i].csr_val);
         end else begin
            issue_request(plan[row_i].op, plan[row_i].cpu, plan[row_i].page,
                          plan[row_i].typed, plan[row_i].want);
         end
      end

      for (ph = 0; ph < 4; ph++) begin
         wait_drained();
         case (ph)
            0: begin
               lo = LOWEST_RESET;
               lim = LIMIT_RESET;
               free_pct = 60;
            end
            1: begin
               lo = CSR_DATA_W'($urandom_range(0, 400));
               lim = CSR_DATA_W'($urandom_range(lo + 64, 1024));
               free_pct = 50;
            end
            2: begin
               lo = {$urandom_range(0, 1) == 1, 10'd0};
               lim = 11'd2047;
               free_pct = 65;
            end
            default: begin
               lo = CSR_DATA_W'($urandom_range(0, 1023));
               lim = CSR_DATA_W'($urandom_range(0, 2047));
               free_pct = 35;
            end
         endcase
         write_csr(CSR_LOWEST_PAGE, lo);
         write_csr(CSR_PAGE_LIMIT, lim);
         // frees land on a subset of cpus so the others have to steal
         free_mask = 8'($urandom_range(0, 255)) | (8'd1 << $urandom_range(0, 7));
         hi = (cfg_limit > NFRAMES) ? NFRAMES : cfg_limit;

         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (run_left == 0) begin
               no_idle = ($urandom_range(0, 3) == 0);
               run_left = $urandom_range(20, 60);
            end
            run_left--;
            op = OP_ALLOC;
            cpu = CPU_FIELD_W'($urandom_range(0, NCPU - 1));
            page = PAGE_W'($urandom_range(0, NFRAMES - 1));
            if ($urandom_range(0, 99) < free_pct) begin
               op = OP_FREE;
               do cpu = CPU_FIELD_W'($urandom_range(0, NCPU - 1)); while (!free_mask[cpu]);
               if ($urandom_range(0, 3) != 0 && hi > cfg_lowest)
                  page = PAGE_W'($urandom_range(cfg_lowest, hi - 1));
               // never push a frame that already sits on a list
               if (accepts_frame(page) && on_list[page] != 0) begin
                  found = 1'b0;
                  for (s = 0; s < NFRAMES && !found; s++) begin
                     cand = page + s[PAGE_W-1:0];
                     if (accepts_frame(cand) && on_list[cand] == 0) begin
                        page = cand;
                        found = 1'b1;
                     end
                  end
                  if (!found) op = OP_ALLOC;
               end
            end
            issue_request(op, cpu, page, 1'b0, '0);
         end
      end

      no_idle = 1'b0;
      wait_drained();
      repeat (20) @(posedge clock);
      $display("covered %0d local grants, %0d steals, %0d out of memory, %0d frees,",
               n_local, n_steal, n_oom, n_freed);
      $display("%0d rejected frees under several range settings; %0d mismatches",
               n_rejected, bad_count);
      if (bad_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // far beyond the slowest legal run, including long steal walks
   initial begin
      #20000000;
      $display("timeout with %0d responses outstanding", owed_rsp.size());
      $display("status: fail");
      $finish;
   end

endmodule

// ===== per_cpu_page_allocator.f =====
hdl/pcpa_pkg.sv
hdl/per_cpu_page_allocator.sv
tb/per_cpu_page_allocator_tb.sv
